### src/rgb_to_hsv_converter_defines.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Word types, widths and the state carried along the divider cell chain.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned Q_W = 16;
  localparam int unsigned NUM_W = 24;
  localparam int unsigned HDIV_W = 11;
  localparam int unsigned SDIV_W = 8;
  localparam int unsigned CELL_COUNT = NUM_W;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [Q_W-1:0]    hue;
    logic [Q_W-1:0]    saturation;
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] alpha_out;
  } pixel_out_t;

  typedef struct packed {
    logic [HDIV_W-1:0] hue_rem;
    logic [HDIV_W-1:0] hue_div;
    logic [NUM_W-1:0]  hue_num;
    logic [Q_W-1:0]    hue_q;
    logic [SDIV_W-1:0] sat_rem;
    logic [SDIV_W-1:0] sat_div;
    logic [NUM_W-1:0]  sat_num;
    logic [Q_W-1:0]    sat_q;
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] alpha;
  } cell_t;

endpackage

### src/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// RGB to HSV input stage
// Finds value and delta, forms the hue numerator and both dividends, and
// registers the starting state for the divider chain.
// ----------------------------------------------------------------------------
module rgbhsv_prep import rgbhsv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  pixel_in_t pixel_i,
  output logic      valid_o,
  output cell_t     data_o
);

  logic               valid_r;
  cell_t              data_r;
  cell_t              data_nxt;
  logic [CHAN_W-1:0]  hi;
  logic [CHAN_W-1:0]  lo;
  logic [CHAN_W-1:0]  delta;
  logic signed [11:0] r_s;
  logic signed [11:0] g_s;
  logic signed [11:0] b_s;
  logic signed [11:0] d_s;
  logic signed [11:0] six_d;
  logic signed [11:0] n_raw;
  logic signed [11:0] n_fix;

  always_comb begin
    hi = pixel_i.red;
    lo = pixel_i.red;
    if (pixel_i.green > hi) hi = pixel_i.green;
    if (pixel_i.blue > hi) hi = pixel_i.blue;
    if (pixel_i.green < lo) lo = pixel_i.green;
    if (pixel_i.blue < lo) lo = pixel_i.blue;
    delta = hi - lo;

    r_s   = signed'({4'b0, pixel_i.red});
    g_s   = signed'({4'b0, pixel_i.green});
    b_s   = signed'({4'b0, pixel_i.blue});
    d_s   = signed'({4'b0, delta});
    six_d = (d_s <<< 2) + (d_s <<< 1);

    if (hi == pixel_i.red) begin
      n_raw = g_s - b_s;
    end else if (hi == pixel_i.green) begin
      n_raw = (d_s <<< 1) + b_s - r_s;
    end else begin
      n_raw = (d_s <<< 2) + r_s - g_s;
    end
    n_fix = (n_raw < 12'sd0) ? n_raw + six_d : n_raw;

    data_nxt.hue_rem = {8'b0, n_fix[10:8]};
    data_nxt.hue_num = {n_fix[7:0], 16'b0};
    data_nxt.hue_div = (delta == '0) ? HDIV_W'(1) : six_d[HDIV_W-1:0];
    data_nxt.hue_q   = '0;
    data_nxt.sat_rem = '0;
    data_nxt.sat_num = {delta, 16'b0} - {16'b0, delta};
    data_nxt.sat_div = (hi == '0) ? SDIV_W'(1) : hi;
    data_nxt.sat_q   = '0;
    data_nxt.value   = hi;
    data_nxt.alpha   = pixel_i.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

### src/rgbhsv_cell.sv
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step for the hue and saturation quotients, passed
// to the next cell each cycle.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_defines.svh"

module rgbhsv_cell import rgbhsv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  input  cell_t data_i,
  output logic  valid_o,
  output cell_t data_o
);

  logic              valid_r;
  cell_t             data_r;
  cell_t             data_nxt;
  logic [HDIV_W:0]   h_trial;
  logic [HDIV_W:0]   h_diff;
  logic              h_ge;
  logic [SDIV_W:0]   s_trial;
  logic [SDIV_W:0]   s_diff;
  logic              s_ge;

  always_comb begin
    h_trial = {data_i.hue_rem, data_i.hue_num[NUM_W-1]};
    h_diff  = h_trial - {1'b0, data_i.hue_div};
    h_ge    = h_trial >= {1'b0, data_i.hue_div};
    s_trial = {data_i.sat_rem, data_i.sat_num[NUM_W-1]};
    s_diff  = s_trial - {1'b0, data_i.sat_div};
    s_ge    = s_trial >= {1'b0, data_i.sat_div};

    data_nxt         = data_i;
    data_nxt.hue_rem = h_ge ? h_diff[HDIV_W-1:0] : h_trial[HDIV_W-1:0];
    data_nxt.hue_num = {data_i.hue_num[NUM_W-2:0], 1'b0};
    data_nxt.hue_q   = {data_i.hue_q[Q_W-2:0], h_ge};
    data_nxt.sat_rem = s_ge ? s_diff[SDIV_W-1:0] : s_trial[SDIV_W-1:0];
    data_nxt.sat_num = {data_i.sat_num[NUM_W-2:0], 1'b0};
    data_nxt.sat_q   = {data_i.sat_q[Q_W-2:0], s_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

  // The partial remainder must always stay below its divisor.
  `RHC_ASSERT(a_hue_rem_bound, !valid_r || (data_r.hue_rem < data_r.hue_div), "hue remainder overflow")
  `RHC_ASSERT(a_sat_rem_bound, !valid_r || (data_r.sat_rem < data_r.sat_div), "saturation remainder overflow")
  `RHC_ASSERT_NEXT(a_valid_follow, valid_i, valid_r, "cell dropped a word")

endmodule

### src/rgb_to_hsv_converter.sv
// Throughput: one pixel word per clock; busy is held low at all times.
// Each pixel word passes through one input stage and then a chain of 24 divider cells.
// Reset clears only the valid pipeline; in-flight words are discarded.
// The receiver cannot stall, so each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts an RGBA pixel to hue, saturation, value and alpha through a
// pipelined chain of restoring divider cells.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  pixel_in_t  in_pixel,
  output logic       out_valid,
  output pixel_out_t out_pixel
);

  localparam int unsigned LATENCY = CELL_COUNT + 1;

  logic  chain_valid [CELL_COUNT+1];
  cell_t chain_data  [CELL_COUNT+1];

  assign busy = 1'b0;

  rgbhsv_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .pixel_i (in_pixel),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  assign out_valid            = chain_valid[CELL_COUNT];
  assign out_pixel.hue        = chain_data[CELL_COUNT].hue_q;
  assign out_pixel.saturation = chain_data[CELL_COUNT].sat_q;
  assign out_pixel.value      = chain_data[CELL_COUNT].value;
  assign out_pixel.alpha_out  = chain_data[CELL_COUNT].alpha;

  `RHC_ASSERT(a_never_busy, !busy, "busy raised")
  `RHC_ASSERT(a_black_sat, !out_valid || (out_pixel.value != '0) || (out_pixel.saturation == '0), "black pixel with saturation")
  `RHC_ASSERT(a_latency, (start && !busy) |-> ##LATENCY out_valid, "result missing after latency")

endmodule
